[rtl/core/prc_pkg.sv]
`timescale 1ns / 1ps
// Package for the polyline rectangle clipper: widths, register indexes and
// payload types. Used by the interfaces, the divider and the top level.
package prc_pkg;
  localparam int COORD_BITS = 16;
  localparam int T_FRAC_BITS = 16;
  localparam int T_BITS = T_FRAC_BITS + 1;
  localparam int D_BITS = COORD_BITS + 1;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_LEFT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TOP = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOTTOM = 2'd3;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic first_vertex;
    logic last_vertex;
  } vertex_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic new_piece;
    logic last_of_run;
  } point_t;

  typedef struct packed {
    logic [CFG_IDX_BITS-1:0] index;
    logic [COORD_BITS-1:0] data;
  } cfg_t;
endpackage

[rtl/core/prc_vertex_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for vertices, points and register writes.
// Depends on prc_pkg.
interface prc_vertex_if;
  logic valid;
  logic ready;
  prc_pkg::vertex_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface prc_point_if;
  logic valid;
  logic ready;
  prc_pkg::point_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface prc_cfg_if;
  logic valid;
  logic ready;
  prc_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/prc_divider.sv]
`timescale 1ns / 1ps
// Radix-2 restoring divider giving t = round(num * 2^F / den), num <= den.
// Depends on prc_pkg.
module prc_divider (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [prc_pkg::D_BITS-1:0] num,
  input  logic [prc_pkg::D_BITS-1:0] den,
  output logic done,
  output logic [prc_pkg::T_BITS-1:0] quot
);
  localparam int R_BITS = prc_pkg::D_BITS + 1;
  localparam int QB = prc_pkg::T_BITS;
  localparam int STEPS = prc_pkg::T_FRAC_BITS;
  localparam int CNT_BITS = $clog2(STEPS);

  logic [R_BITS-1:0] rem;
  logic [prc_pkg::D_BITS-1:0] dv;
  logic [QB-1:0] q;
  logic [CNT_BITS-1:0] cnt;
  logic busy;
  logic [R_BITS-1:0] shifted;
  logic ge;

  // Each step doubles the partial remainder and subtracts the divisor when it fits.
  assign shifted = {rem[R_BITS-2:0], 1'b0};
  assign ge = shifted >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
      rem <= '0;
      dv <= '0;
      q <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        dv <= den;
        if (num >= den) begin
          rem <= {1'b0, num - den};
          q <= QB'(1);
        end else begin
          rem <= {1'b0, num};
          q <= '0;
        end
        cnt <= CNT_BITS'(STEPS - 1);
      end else if (busy) begin
        rem <= ge ? shifted - {1'b0, dv} : shifted;
        q <= {q[QB-2:0], ge};
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // The quotient is rounded half up: one is added when twice the final
  // remainder reaches the divisor.
  assign quot = q + QB'(ge);
endmodule

[rtl/core/polyline_rect_clipper.sv]
`timescale 1ns / 1ps
// Top level of the polyline rectangle clipper (Liang-Barsky).
// Depends on prc_pkg, the channel interfaces and prc_divider.
//
//  channel   dir  payload
//  vin       in   vertex_x, vertex_y, first_vertex, last_vertex
//  pout      out  point_x, point_y, new_piece, last_of_run
//  cfg       in   index, data (rect_left, rect_top, rect_right, rect_bottom)
//
// Each boundary passes S_EDGE and S_CHECK, plus S_DIV and S_DIVWAIT when it needs
// a division on the shared divider; a visible segment then has four S_MUL steps,
// S_DECIDE, S_OUT0 for the start point when needed and S_OUT1 for the end point.
// rst is synchronous and clears the sequencer and polyline state.
// Results wait in the output register while pout.ready is low, and the next
// vertex is taken only after the last result transfer.
module polyline_rect_clipper (
  input logic clk,
  input logic rst,
  prc_vertex_if.sink vin,
  prc_point_if.source pout,
  prc_cfg_if.sink cfg
);
  localparam int CB = prc_pkg::COORD_BITS;
  localparam int DB = prc_pkg::D_BITS;
  localparam int TB = prc_pkg::T_BITS;
  localparam int F = prc_pkg::T_FRAC_BITS;
  localparam int WB = CB + 2;
  localparam logic [TB-1:0] T_ONE = TB'(1) << F;

  typedef enum logic [3:0] {
    S_IDLE, S_EDGE, S_DIV, S_DIVWAIT, S_CHECK, S_MUL, S_DECIDE, S_OUT0, S_OUT1
  } state_t;

  state_t state;
  logic signed [CB-1:0] rl, rt, rr, rb;
  logic signed [CB-1:0] prev_x, prev_y, last_out_x, last_out_y;
  logic piece_pending;
  logic signed [CB-1:0] cx, cy;
  logic signed [DB-1:0] dx, dy;
  logic [TB-1:0] tlo, thi;
  logic [1:0] eidx;
  logic vis;
  logic [1:0] midx;
  logic signed [CB-1:0] sx0, sy0, ex, ey;
  logic enter;
  logic [DB-1:0] dnum, dden;
  logic div_start, div_done;
  logic [TB-1:0] div_quot;
  logic need_start;
  logic out_load;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      rl <= '0;
      rt <= '0;
      rr <= {1'b0, {(CB-1){1'b1}}};
      rb <= {1'b0, {(CB-1){1'b1}}};
    end else if (cfg.valid) begin
      case (cfg.data.index)
        prc_pkg::REG_LEFT: rl <= cfg.data.data;
        prc_pkg::REG_TOP: rt <= cfg.data.data;
        prc_pkg::REG_RIGHT: rr <= cfg.data.data;
        prc_pkg::REG_BOTTOM: rb <= cfg.data.data;
        default: ;
      endcase
    end
  end

  // Edge parameters p, q for the current boundary, each 18 bits signed.
  logic signed [WB-1:0] p, q;
  always_comb begin
    case (eidx)
      2'd0: begin p = -WB'(dx); q = WB'(prev_x) - WB'(rl); end
      2'd1: begin p = WB'(dx); q = WB'(rr) - WB'(prev_x); end
      2'd2: begin p = -WB'(dy); q = WB'(prev_y) - WB'(rt); end
      default: begin p = WB'(dy); q = WB'(rb) - WB'(prev_y); end
    endcase
  end

  logic signed [WB-1:0] np, nq;
  assign np = -p;
  assign nq = -q;

  assign div_start = (state == S_DIV);

  prc_divider u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .num(dnum),
    .den(dden),
    .done(div_done),
    .quot(div_quot)
  );

  // Interpolation multiply: one 17x17 per cycle, operands muxed by midx.
  logic signed [DB-1:0] md;
  logic signed [CB-1:0] ma;
  logic [TB-1:0] mt;
  logic [DB-1:0] mabs;
  logic [DB+TB-1:0] prod;
  logic [CB:0] rnd;
  logic signed [CB-1:0] mres;
  always_comb begin
    md = midx[0] ? dy : dx;
    ma = midx[0] ? prev_y : prev_x;
    mt = midx[1] ? thi : tlo;
    mabs = md[DB-1] ? DB'(-md) : DB'(md);
    prod = (DB+TB)'(mabs) * (DB+TB)'(mt) + (DB+TB)'(T_ONE >> 1);
    rnd = (CB+1)'(prod >> F);
    mres = md[DB-1] ? CB'(WB'(ma) - WB'(rnd)) : CB'(WB'(ma) + WB'(rnd));
  end

  logic vtx_in_rect;
  assign vtx_in_rect = vin.data.vertex_x >= rl && vin.data.vertex_x <= rr &&
                       vin.data.vertex_y >= rt && vin.data.vertex_y <= rb;

  assign vin.ready = (state == S_IDLE) && !pout.valid;
  assign need_start = piece_pending || sx0 != last_out_x || sy0 != last_out_y;

  always_comb begin
    case (state)
      S_IDLE: out_load = vin.valid && vin.ready && vin.data.first_vertex &&
                         vin.data.last_vertex && vtx_in_rect;
      S_OUT0: out_load = !pout.valid;
      S_OUT1: out_load = !pout.valid || pout.ready;
      default: out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pout.valid <= 1'b0;
      prev_x <= '0;
      prev_y <= '0;
      last_out_x <= '0;
      last_out_y <= '0;
      piece_pending <= 1'b1;
      tlo <= '0;
      thi <= T_ONE;
    end else begin
      if (out_load) pout.valid <= 1'b1;
      else if (pout.ready) pout.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (vin.valid && vin.ready) begin
            if (vin.data.first_vertex) begin
              prev_x <= vin.data.vertex_x;
              prev_y <= vin.data.vertex_y;
              piece_pending <= 1'b1;
              if (vin.data.last_vertex && vtx_in_rect) begin
                pout.data <= {vin.data.vertex_x, vin.data.vertex_y, 1'b1, 1'b1};
                last_out_x <= vin.data.vertex_x;
                last_out_y <= vin.data.vertex_y;
                piece_pending <= 1'b0;
              end
            end else begin
              cx <= vin.data.vertex_x;
              cy <= vin.data.vertex_y;
              dx <= DB'(vin.data.vertex_x) - DB'(prev_x);
              dy <= DB'(vin.data.vertex_y) - DB'(prev_y);
              tlo <= '0;
              thi <= T_ONE;
              eidx <= 2'd0;
              vis <= 1'b1;
              state <= S_EDGE;
            end
          end
        end
        S_EDGE: begin
          if (p == 0) begin
            if (q < 0) vis <= 1'b0;
            state <= S_CHECK;
          end else if (p < 0) begin
            if (q > 0) state <= S_CHECK;
            else if (nq > np) begin vis <= 1'b0; state <= S_CHECK; end
            else begin
              enter <= 1'b1;
              dnum <= DB'(nq);
              dden <= DB'(np);
              state <= S_DIV;
            end
          end else begin
            if (q < 0) begin vis <= 1'b0; state <= S_CHECK; end
            else if (q >= p) state <= S_CHECK;
            else begin
              enter <= 1'b0;
              dnum <= DB'(q);
              dden <= DB'(p);
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          state <= S_DIVWAIT;
        end
        S_DIVWAIT: begin
          if (div_done) begin
            if (enter) begin
              if (div_quot > tlo) tlo <= div_quot;
            end else begin
              if (div_quot < thi) thi <= div_quot;
            end
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!vis) begin
            prev_x <= cx; prev_y <= cy; state <= S_IDLE;
          end else if (eidx != 2'd3) begin
            eidx <= eidx + 1'b1; state <= S_EDGE;
          end else if (tlo > thi) begin
            prev_x <= cx; prev_y <= cy; state <= S_IDLE;
          end else begin
            midx <= 2'd0; state <= S_MUL;
          end
        end
        S_MUL: begin
          case (midx)
            2'd0: sx0 <= mres;
            2'd1: sy0 <= mres;
            2'd2: ex <= mres;
            default: ey <= mres;
          endcase
          midx <= midx + 1'b1;
          if (midx == 2'd3) state <= S_DECIDE;
        end
        S_DECIDE: begin
          state <= need_start ? S_OUT0 : S_OUT1;
        end
        S_OUT0: begin
          if (!pout.valid) begin
            pout.data <= {sx0, sy0, 1'b1, 1'b0};
            state <= S_OUT1;
          end
        end
        S_OUT1: begin
          if (!pout.valid || pout.ready) begin
            pout.data <= {ex, ey, 1'b0, 1'b1};
            last_out_x <= ex;
            last_out_y <= ey;
            piece_pending <= 1'b0;
            prev_x <= cx;
            prev_y <= cy;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_tlo_range: assert property (@(posedge clk) disable iff (rst)
    tlo <= T_ONE) else $error("entry parameter above one");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !vin.ready) else $error("ready while busy");
  a_last_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT1 && (!pout.valid || pout.ready)) |=> pout.valid)
    else $error("end point lost");
`endif
endmodule
